[rtl/core/pic_pkg.sv]
`default_nettype none

package pic_pkg;

  // Bus actions carried by an input item.
  typedef enum logic [1:0] {
    ACT_READ  = 2'd0,
    ACT_WRITE = 2'd1,
    ACT_RAISE = 2'd2,
    ACT_CLEAR = 2'd3
  } action_t;

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_MEM,
    ST_SCAN
  } state_t;

  // Register window that an address falls into.
  typedef enum logic [2:0] {
    DEC_NONE,
    DEC_PRIO,
    DEC_PEND,
    DEC_ENABLE,
    DEC_THRESH,
    DEC_CLAIM
  } dec_kind_t;

  localparam int ADDR_W     = 26;
  localparam int DATA_W     = 32;
  localparam int SRC_W      = 5;
  localparam int SIZE_W     = 3;
  localparam int CTX_IDX_W  = 4;
  localparam int PRIO_DEPTH = 32;

  localparam int DEF_NUM_SOURCES  = 31;
  localparam int DEF_NUM_CONTEXTS = 1;

  localparam logic [ADDR_W-1:0] PEND_OFS   = 26'h000_1000;
  localparam logic [ADDR_W-1:0] ENABLE_OFS = 26'h000_2000;
  localparam logic [ADDR_W-1:0] CTX_OFS    = 26'h020_0000;

  // Decoded address, handed from the decoder to the sequencer.
  typedef struct packed {
    dec_kind_t              kind;
    logic [SRC_W-1:0]       prio_id;
    logic [CTX_IDX_W-1:0]   ctx;
  } dec_t;

  // Byte mask for an access of the given size; sizes of four and above act as four.
  function automatic logic [DATA_W-1:0] size_mask(input logic [SIZE_W-1:0] size);
    logic [DATA_W-1:0] m;
    unique case (size)
      3'd0:    m = 32'h0000_0000;
      3'd1:    m = 32'h0000_00FF;
      3'd2:    m = 32'h0000_FFFF;
      3'd3:    m = 32'h00FF_FFFF;
      default: m = 32'hFFFF_FFFF;
    endcase
    return m;
  endfunction

  // Align a register value to the addressed byte lane and cut it to size.
  function automatic logic [DATA_W-1:0] shape_read(input logic [DATA_W-1:0] v,
                                                   input logic [1:0] lane,
                                                   input logic [SIZE_W-1:0] size);
    logic [4:0] sh;
    sh = {lane, 3'b000};
    return (v >> sh) & size_mask(size);
  endfunction

  // Merge write data into the addressed byte lanes; bytes past bit 31 drop off.
  function automatic logic [DATA_W-1:0] merge(input logic [DATA_W-1:0] old,
                                              input logic [1:0] lane,
                                              input logic [SIZE_W-1:0] size,
                                              input logic [DATA_W-1:0] data);
    logic [DATA_W-1:0] m;
    logic [4:0]        sh;
    m  = size_mask(size);
    sh = {lane, 3'b000};
    return (old & ~(m << sh)) | ((data & m) << sh);
  endfunction

endpackage

`default_nettype wire

[rtl/core/pic_prio_mem.sv]
`default_nettype none

module pic_prio_mem
  import pic_pkg::*;
(
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         rd_en,
  input  wire logic [SRC_W-1:0]             rd_addr,
  output logic      [DATA_W-1:0]            rd_data,
  input  wire logic                         wr_en,
  input  wire logic [SRC_W-1:0]             wr_addr,
  input  wire logic [DATA_W-1:0]            wr_data
);

  logic [DATA_W-1:0]     mem [PRIO_DEPTH];
  logic [PRIO_DEPTH-1:0] valid_r;
  logic [DATA_W-1:0]     rdata_r;
  logic                  hit_r;

  // Storage array with a registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata_r <= mem[rd_addr];
    end
  end

  // Valid bits stand in for a zeroed array after reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      hit_r   <= 1'b0;
    end else begin
      if (wr_en) begin
        valid_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        hit_r <= valid_r[rd_addr];
      end
    end
  end

  // An entry never written reads as zero.
  assign rd_data = hit_r ? rdata_r : '0;

endmodule

`default_nettype wire

[rtl/core/pic_decode.sv]
`default_nettype none

module pic_decode
  import pic_pkg::*;
#(
  parameter int NUM_SOURCES  = DEF_NUM_SOURCES,
  parameter int NUM_CONTEXTS = DEF_NUM_CONTEXTS
) (
  input  wire logic [ADDR_W-1:0] addr,
  output dec_t                   dec
);

  logic [9:0]        prio_idx;
  logic [20:0]       en_off;
  logic [13:0]       en_ctx;
  logic [ADDR_W-1:0] ctx_off;
  logic [13:0]       ctx_ctx;

  // Offsets into the enable and per-context windows.
  assign prio_idx = addr[11:2];
  assign en_off   = addr[20:0] - ENABLE_OFS[20:0];
  assign en_ctx   = en_off[20:7];
  assign ctx_off  = addr - CTX_OFS;
  assign ctx_ctx  = ctx_off[25:12];

  // Window select, in address order.
  always_comb begin
    dec.kind    = DEC_NONE;
    dec.prio_id = prio_idx[SRC_W-1:0];
    dec.ctx     = '0;
    priority if (addr < PEND_OFS) begin
      if (prio_idx <= 10'(NUM_SOURCES)) begin
        dec.kind = DEC_PRIO;
      end
    end else if (addr < ENABLE_OFS) begin
      dec.kind = DEC_PEND;
    end else if (addr < CTX_OFS) begin
      dec.ctx = en_ctx[CTX_IDX_W-1:0];
      if (en_ctx < 14'(NUM_CONTEXTS)) begin
        dec.kind = DEC_ENABLE;
      end
    end else begin
      dec.ctx = ctx_ctx[CTX_IDX_W-1:0];
      if (ctx_ctx < 14'(NUM_CONTEXTS)) begin
        priority if (addr[11:0] < 12'd4) begin
          dec.kind = DEC_THRESH;
        end else if (addr[11:0] < 12'd8) begin
          dec.kind = DEC_CLAIM;
        end else begin
          dec.kind = DEC_NONE;
        end
      end
    end
  end

endmodule

`default_nettype wire

[rtl/core/platform_interrupt_controller_unit.sv]
`default_nettype none

// Interrupt controller with a register bus and source raise/clear events.
// Input channel: in_action, in_address, in_access_size, in_write_data and
// in_source_id are taken at a rising edge where start is high and busy is low.
// Every accepted item gives exactly one result: out_read_data, marked by a
// one-cycle out_valid strobe (zero for anything but a bus read).
// Path from the accepting edge to the strobe: every item passes the execute
// state; priority reads of sources 0 to NUM_SOURCES and priority writes of
// sources 1 to NUM_SOURCES then pass the memory state (a read-modify-write of
// the priority RAM for writes); claim reads then pass the scan state, one
// priority RAM read per source from 1 to NUM_SOURCES.
// busy drops in the cycle the strobe appears, so a new item can be accepted
// at that cycle's closing edge; the claim scan through the priority RAM
// sets the worst-case rate.
// Reset (synchronous, rst_n low) zeroes pending bits, enables, thresholds and
// all priorities (through per-entry valid bits, so no clearing pass is needed)
// and returns the sequencer to idle.
// Results cannot be held off: the receiver takes each one in its strobe cycle.
module platform_interrupt_controller_unit
  import pic_pkg::*;
#(
  parameter int NUM_SOURCES  = DEF_NUM_SOURCES,
  parameter int NUM_CONTEXTS = DEF_NUM_CONTEXTS
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   start,
  output logic                        busy,
  input  wire logic [1:0]             in_action,
  input  wire logic [ADDR_W-1:0]      in_address,
  input  wire logic [SIZE_W-1:0]      in_access_size,
  input  wire logic [DATA_W-1:0]      in_write_data,
  input  wire logic [SRC_W-1:0]       in_source_id,
  output logic                        out_valid,
  output logic [DATA_W-1:0]           out_read_data
);

  localparam int CtxW = (NUM_CONTEXTS > 1) ? $clog2(NUM_CONTEXTS) : 1;
  localparam logic [SRC_W-1:0] MaxSrc = SRC_W'(NUM_SOURCES);

  state_t              state_r, state_nxt;
  action_t             act_r;
  logic [ADDR_W-1:0]   addr_r;
  logic [SIZE_W-1:0]   size_r;
  logic [DATA_W-1:0]   wdata_r;
  logic [SRC_W-1:0]    src_r;
  logic [DATA_W-1:0]   pend_r, pend_nxt;
  logic [DATA_W-1:0]   en_r  [NUM_CONTEXTS];
  logic [DATA_W-1:0]   thr_r [NUM_CONTEXTS];
  logic [SRC_W-1:0]    idx_r, idx_nxt;
  logic [DATA_W-1:0]   best_r, best_nxt;
  logic [SRC_W-1:0]    pick_r, pick_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [DATA_W-1:0]   out_data_r, out_data_nxt;

  dec_t                dec;
  logic [CtxW-1:0]     ci;
  logic [1:0]          lane;
  logic                src_ok;
  logic                en_we, thr_we;
  logic [DATA_W-1:0]   en_merged, thr_merged;
  logic                scan_hit;
  logic [SRC_W-1:0]    scan_pick;
  logic [DATA_W-1:0]   scan_best;

  logic                mem_rd_en;
  logic [SRC_W-1:0]    mem_rd_addr;
  logic [DATA_W-1:0]   mem_rd_data;
  logic                mem_wr_en;
  logic [DATA_W-1:0]   mem_wr_data;

  // Address decode of the held item.
  pic_decode #(
    .NUM_SOURCES  (NUM_SOURCES),
    .NUM_CONTEXTS (NUM_CONTEXTS)
  ) u_decode (
    .addr (addr_r),
    .dec  (dec)
  );

  // Source priority RAM.
  pic_prio_mem u_prio_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data),
    .wr_en   (mem_wr_en),
    .wr_addr (dec.prio_id),
    .wr_data (mem_wr_data)
  );

  assign ci          = dec.ctx[CtxW-1:0];
  assign lane        = addr_r[1:0];
  assign src_ok      = (src_r != '0) && (src_r <= MaxSrc);
  assign en_merged   = merge(en_r[ci], lane, size_r, wdata_r);
  assign thr_merged  = merge(thr_r[ci], lane, size_r, wdata_r);
  assign mem_wr_data = merge(mem_rd_data, lane, size_r, wdata_r);

  // One scan step: the source whose priority just came out of the RAM.
  assign scan_hit  = pend_r[idx_r] && en_r[ci][idx_r] &&
                     (mem_rd_data > best_r) && (mem_rd_data > thr_r[ci]);
  assign scan_pick = scan_hit ? idx_r : pick_r;
  assign scan_best = scan_hit ? mem_rd_data : best_r;

  // Sequencer: next state, RAM control and result.
  always_comb begin
    state_nxt     = state_r;
    pend_nxt      = pend_r;
    idx_nxt       = idx_r;
    best_nxt      = best_r;
    pick_nxt      = pick_r;
    out_valid_nxt = 1'b0;
    out_data_nxt  = '0;
    mem_rd_en     = 1'b0;
    mem_rd_addr   = dec.prio_id;
    mem_wr_en     = 1'b0;
    en_we         = 1'b0;
    thr_we        = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        state_nxt     = ST_IDLE;
        out_valid_nxt = 1'b1;
        unique case (act_r)
          ACT_RAISE: begin
            if (src_ok) begin
              pend_nxt = pend_r | (32'h1 << src_r);
            end
          end
          ACT_CLEAR: begin
            if (src_ok) begin
              pend_nxt = pend_r & ~(32'h1 << src_r);
            end
          end
          ACT_WRITE: begin
            unique case (dec.kind)
              DEC_PRIO: begin
                if (dec.prio_id != '0) begin
                  mem_rd_en     = 1'b1;
                  out_valid_nxt = 1'b0;
                  state_nxt     = ST_MEM;
                end
              end
              DEC_ENABLE: en_we  = 1'b1;
              DEC_THRESH: thr_we = 1'b1;
              default: ;
            endcase
          end
          ACT_READ: begin
            unique case (dec.kind)
              DEC_PRIO: begin
                mem_rd_en     = 1'b1;
                out_valid_nxt = 1'b0;
                state_nxt     = ST_MEM;
              end
              DEC_PEND:   out_data_nxt = shape_read(pend_r, lane, size_r);
              DEC_ENABLE: out_data_nxt = shape_read(en_r[ci], lane, size_r);
              DEC_THRESH: out_data_nxt = shape_read(thr_r[ci], lane, size_r);
              DEC_CLAIM: begin
                mem_rd_en     = 1'b1;
                mem_rd_addr   = SRC_W'(1);
                idx_nxt       = SRC_W'(1);
                best_nxt      = '0;
                pick_nxt      = '0;
                out_valid_nxt = 1'b0;
                state_nxt     = ST_SCAN;
              end
              default: out_data_nxt = '0;
            endcase
          end
          default: ;
        endcase
      end
      ST_MEM: begin
        state_nxt     = ST_IDLE;
        out_valid_nxt = 1'b1;
        if (act_r == ACT_READ) begin
          out_data_nxt = shape_read(mem_rd_data, lane, size_r);
        end else begin
          mem_wr_en = 1'b1;
        end
      end
      ST_SCAN: begin
        if (idx_r == MaxSrc) begin
          // Last source: claim the winner and return its id.
          state_nxt     = ST_IDLE;
          out_valid_nxt = 1'b1;
          out_data_nxt  = shape_read(DATA_W'(scan_pick), lane, size_r);
          pend_nxt      = pend_r & ~(32'h1 << scan_pick);
        end else begin
          best_nxt    = scan_best;
          pick_nxt    = scan_pick;
          idx_nxt     = idx_r + SRC_W'(1);
          mem_rd_en   = 1'b1;
          mem_rd_addr = idx_r + SRC_W'(1);
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Control and status registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      pend_r      <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < NUM_CONTEXTS; i++) begin
        en_r[i]  <= '0;
        thr_r[i] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
      if (en_we) begin
        en_r[ci] <= en_merged;
      end
      if (thr_we) begin
        thr_r[ci] <= thr_merged;
      end
    end
  end

  // Item capture, scan registers and result data.
  always_ff @(posedge clk) begin
    if ((state_r == ST_IDLE) && start) begin
      act_r   <= action_t'(in_action);
      addr_r  <= in_address;
      size_r  <= in_access_size;
      wdata_r <= in_write_data;
      src_r   <= in_source_id;
    end
    idx_r      <= idx_nxt;
    best_r     <= best_nxt;
    pick_r     <= pick_nxt;
    out_data_r <= out_data_nxt;
  end

  assign busy          = (state_r != ST_IDLE);
  assign out_valid     = out_valid_r;
  assign out_read_data = out_data_r;

  // A result strobe always follows a cycle of work.
  a_strobe_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result strobe without a preceding busy cycle");

  // An accepted item makes the block busy in the next cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted item did not start work");

  // Source zero never becomes pending.
  a_no_src0_pending: assert property (@(posedge clk) disable iff (!rst_n)
    !pend_r[0])
    else $error("pending bit of source zero set");

  // The claim scan stays within the implemented sources.
  a_scan_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |-> ((idx_r != '0) && (idx_r <= MaxSrc)))
    else $error("claim scan index out of range");

endmodule

`default_nettype wire
